FILE: hdl/entity_id_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the identifier allocator
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ENTITY_ID_ALLOCATOR_UNIT_ASSERT_SVH
`define ENTITY_ID_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define EIDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define EIDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/eida_pkg.sv
// ----------------------------------------------------------------------------
// eida_pkg
// Shared command, status and handshake types of the identifier allocator.
// ----------------------------------------------------------------------------
package eida_pkg;

  // Fixed field widths of the stream payloads
  localparam int IdFieldW = 10;
  localparam int CmdW     = 3;
  localparam int StatW    = 3;
  localparam int InDataW  = 16;
  localparam int OutDataW = 24;

  typedef enum logic [CmdW-1:0] {
    CMD_CREATE    = 3'd0,
    CMD_CREATE_AT = 3'd1,
    CMD_DESTROY   = 3'd2,
    CMD_CHECK     = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_RANGE     = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_QFULL     = 3'd4
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic sweep;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_need;
    logic scan_done;
    logic sweep_done;
    logic is_clear;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hdl/eida_ctrl.sv
// ----------------------------------------------------------------------------
// eida_ctrl
// Sequencer of the allocator: bitmap sweep, command fetch, execute, free
// queue walk and result hand-off.
// ----------------------------------------------------------------------------
module eida_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  eida_pkg::dp_stat_t   stat_i,
  output eida_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.scan_need ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = stat_i.is_clear ? S_SWEEP : S_IDLE;
        end
      end
      default: begin
        state_d = S_SWEEP;
      end
    endcase
  end

  // State register; reset starts with a bitmap sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/eida_dpath.sv
// ----------------------------------------------------------------------------
// eida_dpath
// Allocator datapath: alive bitmap, free queue ring, counters, queue walk
// and the output register.
// ----------------------------------------------------------------------------
module eida_dpath #(
  parameter int ID_LIMIT    = 1023,
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  eida_pkg::ctrl_cmd_t                 cmd_i,
  output eida_pkg::dp_stat_t                  stat_o,
  input  logic [eida_pkg::CmdW-1:0]           in_cmd_i,
  input  logic [eida_pkg::IdFieldW-1:0]       in_id_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [eida_pkg::OutDataW-1:0]       out_data_o
);

  localparam int IdNeedW = $clog2(ID_LIMIT + 1);
  localparam int IW      = (IdNeedW > eida_pkg::IdFieldW) ? IdNeedW : eida_pkg::IdFieldW;
  localparam int AAW     = $clog2(ID_LIMIT + 1);
  localparam int QAW     = $clog2(QUEUE_DEPTH);
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IW-1:0]  IdMax     = IW'(ID_LIMIT);
  localparam logic [AAW-1:0] SweepLast = AAW'(ID_LIMIT);
  localparam logic [QAW-1:0] QdLast    = QAW'(QUEUE_DEPTH - 1);
  localparam logic [QAW:0]   QdWide    = (QAW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0]  QdFull    = CW'(QUEUE_DEPTH);

  // Storage
  logic            alive_mem [0:ID_LIMIT];
  logic [IW-1:0]   queue_mem [0:QUEUE_DEPTH-1];
  logic            alive_rd_q;
  logic [IW-1:0]   queue_rd_q;

  // Control registers
  logic [IW-1:0]   nc_q, nc_d;
  logic [QAW-1:0]  head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AAW-1:0]  swp_q, swp_d;
  logic [CW-1:0]   issued_q, issued_d;
  logic [CW-1:0]   kept_q, kept_d;
  logic            pend_q, pend_d;
  logic            out_valid_q;

  // Payload registers
  logic [eida_pkg::CmdW-1:0]  cmd_q;
  logic [IW-1:0]              id_q;
  logic [QAW-1:0]             rd_ptr_q, rd_ptr_d;
  logic [QAW-1:0]             wr_ptr_q, wr_ptr_d;
  logic [IW-1:0]              res_id_q, res_id_d;
  logic                       res_alive_q, res_alive_d;
  logic [eida_pkg::StatW-1:0] res_stat_q, res_stat_d;
  logic [eida_pkg::OutDataW-1:0] out_data_q;

  // Memory ports
  logic            a_we, a_wdata;
  logic [AAW-1:0]  a_waddr, a_raddr;
  logic            q_we;
  logic [QAW-1:0]  q_waddr, q_raddr;
  logic [IW-1:0]   q_wdata;

  // Helpers
  logic [IW-1:0]   in_id_ext;
  logic [QAW:0]    tail_sum;
  logic [QAW-1:0]  tail;
  logic            id_ok, id_hi, got;
  logic [IW-1:0]   new_id;
  logic            issue;
  logic            scan_need, scan_done;

  function automatic logic [QAW-1:0] ring_inc(input logic [QAW-1:0] p);
    ring_inc = (p == QdLast) ? '0 : p + 1'b1;
  endfunction

  assign in_id_ext = IW'(in_id_i);
  assign a_raddr   = in_id_ext[AAW-1:0];
  assign tail_sum  = {1'b0, head_q} + (QAW + 1)'(count_q);
  assign tail      = (tail_sum >= QdWide) ? QAW'(tail_sum - QdWide) : QAW'(tail_sum);
  assign id_ok     = (id_q != '0) && (id_q <= IdMax);
  assign id_hi     = (id_q > IdMax);
  assign issue     = (issued_q != count_q);
  assign scan_done = !issue && !pend_q;
  assign q_raddr   = cmd_i.scan ? rd_ptr_q : head_q;

  // Execute, queue walk and sweep
  always_comb begin
    nc_d        = nc_q;
    head_d      = head_q;
    count_d     = count_q;
    swp_d       = swp_q;
    issued_d    = issued_q;
    kept_d      = kept_q;
    pend_d      = 1'b0;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    res_id_d    = res_id_q;
    res_alive_d = res_alive_q;
    res_stat_d  = res_stat_q;
    a_we        = 1'b0;
    a_waddr     = id_q[AAW-1:0];
    a_wdata     = 1'b0;
    q_we        = 1'b0;
    q_waddr     = tail;
    q_wdata     = id_q;
    got         = 1'b0;
    new_id      = '0;
    scan_need   = 1'b0;

    if (cmd_i.sweep) begin
      // Zero one bitmap entry a cycle
      a_we    = 1'b1;
      a_waddr = swp_q;
      swp_d   = (swp_q == SweepLast) ? '0 : swp_q + 1'b1;
    end

    if (cmd_i.exec) begin
      res_id_d    = '0;
      res_alive_d = id_ok & alive_rd_q;
      res_stat_d  = eida_pkg::ST_OK;
      rd_ptr_d    = head_q;
      wr_ptr_d    = head_q;
      issued_d    = '0;
      kept_d      = '0;
      case (cmd_q)
        eida_pkg::CMD_CREATE, eida_pkg::CMD_CREATE_AT: begin
          if (cmd_q == eida_pkg::CMD_CREATE || id_q == '0) begin
            // Pop the oldest free id, else take a fresh one
            if (count_q != '0) begin
              new_id  = queue_rd_q;
              head_d  = ring_inc(head_q);
              count_d = count_q - 1'b1;
              got     = 1'b1;
            end else if (nc_q >= IdMax) begin
              res_stat_d = eida_pkg::ST_EXHAUSTED;
            end else begin
              new_id = nc_q + 1'b1;
              nc_d   = new_id;
              got    = 1'b1;
            end
            if (got) begin
              a_we     = 1'b1;
              a_waddr  = new_id[AAW-1:0];
              a_wdata  = 1'b1;
              res_id_d = new_id;
            end
            res_alive_d = id_ok & ((got && new_id == id_q) | alive_rd_q);
          end else if (id_hi) begin
            res_stat_d  = eida_pkg::ST_RANGE;
            res_alive_d = 1'b0;
          end else if (alive_rd_q) begin
            res_id_d    = id_q;
            res_alive_d = 1'b1;
          end else begin
            // Claim the id; queued copies are dropped by the walk
            a_we        = 1'b1;
            a_wdata     = 1'b1;
            nc_d        = (id_q > nc_q) ? id_q : nc_q;
            res_id_d    = id_q;
            res_alive_d = 1'b1;
            scan_need   = (count_q != '0);
          end
        end
        eida_pkg::CMD_DESTROY: begin
          if (id_q == '0 || id_q > nc_q || id_hi) begin
            res_stat_d = eida_pkg::ST_IGNORED;
          end else begin
            a_we        = 1'b1;
            res_alive_d = 1'b0;
            if (count_q == QdFull) begin
              res_stat_d = eida_pkg::ST_QFULL;
            end else begin
              q_we    = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
        end
        eida_pkg::CMD_CHECK: begin
          if (id_hi) begin
            res_stat_d = eida_pkg::ST_RANGE;
          end
        end
        eida_pkg::CMD_CLEAR: begin
          nc_d        = '0;
          head_d      = '0;
          count_d     = '0;
          res_alive_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.scan) begin
      // Read ahead one entry, write back every entry that differs
      if (issue) begin
        rd_ptr_d = ring_inc(rd_ptr_q);
        issued_d = issued_q + 1'b1;
      end
      pend_d = issue;
      if (pend_q && queue_rd_q != id_q) begin
        q_we     = 1'b1;
        q_waddr  = wr_ptr_q;
        q_wdata  = queue_rd_q;
        wr_ptr_d = ring_inc(wr_ptr_q);
        kept_d   = kept_q + 1'b1;
      end
      if (scan_done) begin
        count_d = kept_q;
      end
    end
  end

  // Alive bitmap, registered read at the incoming id
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      alive_mem[a_waddr] <= a_wdata;
    end
    alive_rd_q <= alive_mem[a_raddr];
  end

  // Free queue ring, registered read
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    queue_rd_q <= queue_mem[q_raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q        <= '0;
      head_q      <= '0;
      count_q     <= '0;
      swp_q       <= '0;
      issued_q    <= '0;
      kept_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      nc_q     <= nc_d;
      head_q   <= head_d;
      count_q  <= count_d;
      swp_q    <= swp_d;
      issued_q <= issued_d;
      kept_q   <= kept_d;
      pend_q   <= pend_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= in_cmd_i;
      id_q  <= in_id_ext;
    end
    rd_ptr_q    <= rd_ptr_d;
    wr_ptr_q    <= wr_ptr_d;
    res_id_q    <= res_id_d;
    res_alive_q <= res_alive_d;
    res_stat_q  <= res_stat_d;
    if (cmd_i.load_out) begin
      out_data_q <= {res_stat_q, nc_q[eida_pkg::IdFieldW-1:0], res_alive_q,
                     res_id_q[eida_pkg::IdFieldW-1:0]};
    end
  end

  // Status to the controller
  assign stat_o.scan_need  = scan_need;
  assign stat_o.scan_done  = scan_done;
  assign stat_o.sweep_done = (swp_q == SweepLast);
  assign stat_o.is_clear   = (cmd_q == eida_pkg::CMD_CLEAR);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hdl/entity_id_allocator_unit.sv
// A command passes the execute state, an optional queue walk and the done state before
// m_axis_tvalid rises; a held result stalls. No new command is taken until the last
// result is loaded; create-at of a dead id with a non-empty free queue adds a walk of
// the free queue. Reset and clear both run a bitmap sweep over all ID_LIMIT + 1 entries
// (one alive bit per cycle) during which s_axis_tready stays low.
// ----------------------------------------------------------------------------
// entity_id_allocator_unit
// Identifier allocator with a first-in-first-out free list and alive bitmap.
// ----------------------------------------------------------------------------
`include "entity_id_allocator_unit_assert.svh"

module entity_id_allocator_unit #(
  parameter int ID_LIMIT    = 1023,
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] id_in, [15:10] zero
  input  logic [eida_pkg::InDataW-1:0]      s_axis_tdata,
  // [2:0] cmd
  input  logic [eida_pkg::CmdW-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [9:0] id_out, [10] is_alive, [20:11] high_water, [23:21] status
  output logic [eida_pkg::OutDataW-1:0]     m_axis_tdata
);

  eida_pkg::ctrl_cmd_t ctl_cmd;
  eida_pkg::dp_stat_t  dp_stat;

  // Sequencer
  eida_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  // Storage and arithmetic
  eida_dpath #(
    .ID_LIMIT    (ID_LIMIT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctl_cmd),
    .stat_o      (dp_stat),
    .in_cmd_i    (s_axis_tuser),
    .in_id_i     (s_axis_tdata[eida_pkg::IdFieldW-1:0]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

  // Checks
  logic in_xfer, out_free, id_given, st_ok;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign id_given = m_axis_tvalid && (m_axis_tdata[9:0] != 10'd0);
  assign st_ok    = (m_axis_tdata[23:21] == eida_pkg::ST_OK);

  `EIDA_ASSERT_NXT(a_one_in_flight, in_xfer, !s_axis_tready, "input taken mid-command")
  `EIDA_ASSERT_IMP(a_load_when_free, ctl_cmd.load_out, out_free, "result over untaken transfer")
  `EIDA_ASSERT_IMP(a_id_means_ok, id_given, st_ok, "identifier handed out with an error")

endmodule

FILE: tb/sv/entity_id_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// entity_id_allocator_unit_test
// Self-checking bench for the identifier allocator. Commands go in over the
// slave stream, and a behavioural copy of the allocator predicts each result
// as its command transfers. The predicted results wait in order and are
// compared field by field with the master-side transfers. A directed pass
// covers the corner cases, a weighted random mix exercises the free list, and
// a queue overflow pass fills the free list. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module entity_id_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdLimit        = 1023;
  localparam int QueueDepth     = 1024;
  localparam int WatchdogCycles = 20000;
  localparam int DrainCycles    = 12;
  localparam int IdW            = eida_pkg::IdFieldW;
  localparam int CmdW           = eida_pkg::CmdW;

  // Command codes above clear are spare and must act as no-ops
  localparam logic [CmdW-1:0] CmdSpareLo = CmdW'(eida_pkg::CMD_CLEAR) + 1'b1;
  localparam logic [CmdW-1:0] CmdSpareHi = '1;

  // Result layout, most significant field first, matching m_axis_tdata
  typedef struct packed {
    eida_pkg::status_e     status;
    logic [IdW-1:0]        high_water;
    logic                  is_alive;
    logic [IdW-1:0]        id_out;
  } alloc_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // [9:0] id_in, [15:10] zero
  logic [eida_pkg::InDataW-1:0]  s_axis_tdata;
  // [2:0] cmd
  logic [CmdW-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [9:0] id_out, [10] is_alive, [20:11] high_water, [23:21] status
  logic [eida_pkg::OutDataW-1:0] m_axis_tdata;

  // Allocator state as the bench believes it to be
  int                    high_water_q;
  bit                    alive_q [0:IdLimit];
  logic [IdW-1:0]        free_ids [$];

  alloc_result_t         pending_results [$];
  int unsigned           mismatch_count;
  int unsigned           stall_cycles;
  bit                    no_gaps;

  entity_id_allocator_unit #(
    .ID_LIMIT    (IdLimit),
    .QUEUE_DEPTH (QueueDepth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Half the time no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_allocator();
    high_water_q = 0;
    foreach (alive_q[i]) alive_q[i] = 1'b0;
    free_ids.delete();
  endfunction

  // Pop the oldest freed id, else mint a fresh one
  function automatic logic [IdW-1:0] take_free_id(inout eida_pkg::status_e st);
    logic [IdW-1:0] id;
    if (free_ids.size() != 0) begin
      id = free_ids.pop_front();
    end else if (high_water_q >= IdLimit) begin
      st = eida_pkg::ST_EXHAUSTED;
      return '0;
    end else begin
      high_water_q++;
      id = IdW'(high_water_q);
    end
    if (id <= IdLimit) alive_q[id] = 1'b1;
    return id;
  endfunction

  // Apply one command to the bench state and return the result it yields
  function automatic alloc_result_t predict_allocation(logic [CmdW-1:0] cmd,
                                                       logic [IdW-1:0] id);
    alloc_result_t       r;
    logic [IdW-1:0]      kept [$];
    r.status = eida_pkg::ST_OK;
    r.id_out = '0;
    case (cmd)
      eida_pkg::CMD_CREATE: begin
        r.id_out = take_free_id(r.status);
      end
      eida_pkg::CMD_CREATE_AT: begin
        if (id == 0) begin
          r.id_out = take_free_id(r.status);
        end else if (id > IdLimit) begin
          r.status = eida_pkg::ST_RANGE;
        end else if (alive_q[id]) begin
          r.id_out = id;
        end else begin
          // Drop every queued copy, keeping the others in order
          foreach (free_ids[i]) if (free_ids[i] != id) kept.push_back(free_ids[i]);
          free_ids = kept;
          if (id > high_water_q) high_water_q = id;
          alive_q[id] = 1'b1;
          r.id_out = id;
        end
      end
      eida_pkg::CMD_DESTROY: begin
        if (id == 0 || id > high_water_q || id > IdLimit) begin
          r.status = eida_pkg::ST_IGNORED;
        end else begin
          alive_q[id] = 1'b0;
          if (free_ids.size() >= QueueDepth) r.status = eida_pkg::ST_QFULL;
          else free_ids.push_back(id);
        end
      end
      eida_pkg::CMD_CHECK: begin
        if (id > IdLimit) r.status = eida_pkg::ST_RANGE;
      end
      eida_pkg::CMD_CLEAR: begin
        clear_allocator();
      end
      default: ;
    endcase
    r.is_alive   = (id != 0 && id <= IdLimit) ? alive_q[id] : 1'b0;
    r.high_water = IdW'(high_water_q);
    return r;
  endfunction

  // Send one command; entered and left at a falling edge with tvalid held
  task automatic issue_command(input logic [CmdW-1:0] cmd,
                               input logic [IdW-1:0]  id);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(eida_pkg::InDataW-IdW){1'b0}}, id};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_allocation(cmd, id));
    @(negedge clk_i);
  endtask

  // One weighted random command, ids steered towards the live range
  task automatic issue_random_op();
    int unsigned         r;
    int unsigned         s;
    logic [IdW-1:0]      id;
    r  = $urandom_range(0, 99);
    s  = $urandom_range(0, 99);
    id = IdW'($urandom_range(0, IdLimit));
    if (r < 28) begin
      issue_command(eida_pkg::CMD_CREATE, id);
    end else if (r < 48) begin
      if (s < 15) id = '0;
      else if (s < 45 && high_water_q > 0) id = IdW'($urandom_range(1, high_water_q));
      else if (s < 95 && high_water_q < IdLimit)
        id = IdW'($urandom_range(high_water_q + 1,
                                 (high_water_q + 8 > IdLimit) ? IdLimit
                                                               : high_water_q + 8));
      issue_command(eida_pkg::CMD_CREATE_AT, id);
    end else if (r < 76) begin
      if (s < 10) id = '0;
      else if (s < 85 && high_water_q > 0) id = IdW'($urandom_range(1, high_water_q));
      issue_command(eida_pkg::CMD_DESTROY, id);
    end else if (r < 90) begin
      if (s < 70 && high_water_q > 0) id = IdW'($urandom_range(1, high_water_q));
      issue_command(eida_pkg::CMD_CHECK, id);
    end else if (r < 92) begin
      issue_command(eida_pkg::CMD_CLEAR, id);
    end else if (r < 94) begin
      issue_command(CmdW'($urandom_range(CmdSpareLo, CmdSpareHi)), id);
    end else begin
      issue_command(eida_pkg::CMD_CREATE, id);
    end
  endtask

  // Corner cases in a fixed order
  task automatic test_directed();
    issue_command(eida_pkg::CMD_CHECK, 10'd0);
    issue_command(eida_pkg::CMD_CHECK, 10'd1023);
    issue_command(eida_pkg::CMD_CREATE, 10'd0);
    issue_command(eida_pkg::CMD_CREATE, 10'd1023);
    issue_command(eida_pkg::CMD_DESTROY, 10'd0);
    issue_command(eida_pkg::CMD_DESTROY, 10'd5);
    issue_command(eida_pkg::CMD_DESTROY, 10'd1);
    issue_command(eida_pkg::CMD_DESTROY, 10'd1);      // duplicate of a dead id
    issue_command(eida_pkg::CMD_CREATE, 10'd0);
    issue_command(eida_pkg::CMD_CREATE, 10'd0);       // second copy, already alive
    issue_command(eida_pkg::CMD_CREATE_AT, 10'd0);    // behaves as create
    issue_command(eida_pkg::CMD_CREATE_AT, 10'd2);    // alive, handed back unchanged
    issue_command(eida_pkg::CMD_DESTROY, 10'd3);
    issue_command(eida_pkg::CMD_DESTROY, 10'd2);
    issue_command(eida_pkg::CMD_DESTROY, 10'd3);
    issue_command(eida_pkg::CMD_CREATE_AT, 10'd3);    // strips both queued copies
    issue_command(eida_pkg::CMD_CREATE_AT, 10'd1023); // raise the high-water mark to the top
    issue_command(eida_pkg::CMD_CHECK, 10'd1023);
    issue_command(eida_pkg::CMD_CREATE, 10'd0);       // takes the queued 2
    issue_command(eida_pkg::CMD_CREATE, 10'd0);       // nothing left to hand out
    issue_command(CmdSpareLo, 10'd1023);
    issue_command(CmdSpareLo + 1'b1, 10'd512);
    issue_command(CmdSpareHi, 10'd0);
    issue_command(eida_pkg::CMD_CLEAR, 10'd1023);
    issue_command(eida_pkg::CMD_CHECK, 10'd1);
    issue_command(eida_pkg::CMD_CREATE, 10'd0);
  endtask

  // Weighted mix with gap-free stretches now and then
  task automatic test_random_mix(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 150 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      issue_random_op();
    end
    no_gaps = 1'b0;
  endtask

  // Fill the free list, overflow it, then compact it and pop from it
  task automatic test_queue_overflow();
    issue_command(eida_pkg::CMD_CLEAR, 10'd0);
    issue_command(eida_pkg::CMD_CREATE_AT, IdW'(IdLimit));
    no_gaps = 1'b1;
    for (int n = 0; n < QueueDepth; n++) begin
      if (n == QueueDepth / 2) no_gaps = 1'b0;
      issue_command(eida_pkg::CMD_DESTROY, IdW'($urandom_range(1, IdLimit)));
    end
    repeat (3) issue_command(eida_pkg::CMD_DESTROY, IdW'($urandom_range(1, IdLimit)));
    issue_command(eida_pkg::CMD_CHECK, IdW'($urandom_range(1, IdLimit)));
    repeat (4) issue_command(eida_pkg::CMD_CREATE_AT, IdW'($urandom_range(1, IdLimit)));
    repeat (6) issue_command(eida_pkg::CMD_CREATE, 10'd0);
    repeat (20) issue_random_op();
  endtask

  // Receiver side: alternate stalls and ready bursts
  initial begin : out_ready_gen
    int unsigned n;
    m_axis_tready = 1'b0;
    @(negedge clk_i);
    forever begin
      n = pick_gap();
      if (n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
  end

  task automatic report_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, expv, actv);
    end
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    alloc_result_t got;
    alloc_result_t want;
    got = m_axis_tdata;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual %h", $realtime, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        report_field("id_out", want.id_out, got.id_out);
        report_field("is_alive", want.is_alive, got.is_alive);
        report_field("high_water", want.high_water, got.high_water);
        report_field("status", want.status, got.status);
      end
    end
  end

  // Abort when nothing transfers on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogCycles) begin
      $display("%0t: no transfer for %0d cycles", $realtime, WatchdogCycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    no_gaps        = 1'b0;
    clear_allocator();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_mix(760);
    test_queue_overflow();

    // Drain the outstanding results
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
